// ===== src/pgfs_pkg.sv =====
// Package with widths and types shared by the grid factor split block.
`default_nettype none

package pgfs_pkg;

  // Width of the worker count that the block works on.
  localparam int COUNT_BITS = 16;
  // Fixed width of the count and grid ports.
  localparam int FIELD_BITS = 16;
  // Number of digit steps of the square root, two count bits per step.
  localparam int SQ_STEPS = (COUNT_BITS + 1) / 2;
  localparam int DIV_CNT_BITS = $clog2(COUNT_BITS);

  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [COUNT_BITS:0]     wide_t;
  typedef logic [COUNT_BITS+1:0]   square_t;
  typedef logic [FIELD_BITS-1:0]   field_t;
  typedef logic [DIV_CNT_BITS-1:0] div_cnt_t;

  localparam count_t SQ_FIRST_BIT = count_t'(1) << (2 * (SQ_STEPS - 1));
  localparam div_cnt_t DIV_LAST = div_cnt_t'(COUNT_BITS - 1);

endpackage

`default_nettype wire

// ===== src/pencil_grid_factor_split_core.sv =====
// Splits a worker count into a two-dimensional grid by trial division.
//
// Usage: drive rank_count_i and raise start_i. The transaction is taken at
// a rising edge with start_i high and busy_o low; busy_o then stays high
// until the result has been shown. The result appears on grid_first_o,
// grid_second_o and bad_count_o for exactly one cycle, marked by done_o,
// and busy_o falls at the end of that cycle. The receiver cannot stall the
// block, so the result must be captured in the done_o cycle.
// Timing: one transaction at a time. A count of zero goes straight to the
// result. Any other count first runs the square root, one digit per cycle,
// then the trial division. Each divisor candidate costs a check plus one
// restoring division (one quotient bit per cycle on the shared subtractor),
// and each factor found costs a multiply and a compare. The worst case is a
// prime just below 2^16, with 254 failed candidates.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// busy_o and done_o; a transaction in flight is lost.
`default_nettype none

module pencil_grid_factor_split_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire pgfs_pkg::field_t          rank_count_i,
  output logic                           done_o,
  output pgfs_pkg::field_t               grid_first_o,
  output pgfs_pkg::field_t               grid_second_o,
  output logic                           bad_count_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSqrt   = 3'd1;
  localparam logic [2:0] StCheck  = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StMul    = 3'd4;
  localparam logic [2:0] StCmp    = 3'd5;
  localparam logic [2:0] StFinish = 3'd6;

  logic [2:0] state_q, state_d;

  pgfs_pkg::count_t   x_q, x_d;
  pgfs_pkg::count_t   res_q, res_d;
  pgfs_pkg::count_t   bit_q, bit_d;
  pgfs_pkg::count_t   s_q, s_d;
  pgfs_pkg::count_t   m_q, m_d;
  pgfs_pkg::count_t   d_q, d_d;
  pgfs_pkg::square_t  dsq_q, dsq_d;
  pgfs_pkg::count_t   rem_q, rem_d;
  pgfs_pkg::count_t   quo_q, quo_d;
  pgfs_pkg::div_cnt_t cnt_q, cnt_d;
  pgfs_pkg::count_t   f_q, f_d;
  pgfs_pkg::count_t   first_q, first_d;
  logic               bad_q, bad_d;

  pgfs_pkg::count_t   count_in;
  pgfs_pkg::wide_t    sub_a, sub_b;
  logic [pgfs_pkg::COUNT_BITS+1:0] sub_diff;
  logic               sub_ge;
  pgfs_pkg::wide_t    rem_shift;
  logic [2*pgfs_pkg::COUNT_BITS-1:0] product;

  assign count_in = pgfs_pkg::count_t'(rank_count_i);
  assign rem_shift = {rem_q, quo_q[pgfs_pkg::COUNT_BITS-1]};

  // Shared compare and subtract unit: square root digits and division bits.
  always_comb begin
    if (state_q == StSqrt) begin
      sub_a = {1'b0, x_q};
      sub_b = {1'b0, res_q} + {1'b0, bit_q};
    end else begin
      sub_a = rem_shift;
      sub_b = {1'b0, d_q};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = ~sub_diff[pgfs_pkg::COUNT_BITS+1];
  end

  assign product = {{pgfs_pkg::COUNT_BITS{1'b0}}, first_q}
                 * {{pgfs_pkg::COUNT_BITS{1'b0}}, f_q};

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    res_d   = res_q;
    bit_d   = bit_q;
    s_d     = s_q;
    m_d     = m_q;
    d_d     = d_q;
    dsq_d   = dsq_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    f_d     = f_q;
    first_d = first_q;
    bad_d   = bad_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          first_d = pgfs_pkg::count_t'(1);
          if (count_in == '0) begin
            m_d     = pgfs_pkg::count_t'(1);
            bad_d   = 1'b1;
            state_d = StFinish;
          end else begin
            m_d     = count_in;
            x_d     = count_in;
            res_d   = '0;
            bit_d   = pgfs_pkg::SQ_FIRST_BIT;
            bad_d   = 1'b0;
            state_d = StSqrt;
          end
        end
      end
      StSqrt: begin
        if (sub_ge) begin
          x_d   = sub_diff[pgfs_pkg::COUNT_BITS-1:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == pgfs_pkg::count_t'(1)) begin
          s_d     = res_d;
          d_d     = pgfs_pkg::count_t'(2);
          dsq_d   = pgfs_pkg::square_t'(4);
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (m_q == pgfs_pkg::count_t'(1)) begin
          state_d = StFinish;
        end else if (dsq_q > {2'b00, m_q}) begin
          // No divisor up to the square root is left: the cofactor is prime.
          f_d     = m_q;
          m_d     = pgfs_pkg::count_t'(1);
          state_d = StMul;
        end else begin
          rem_d   = '0;
          quo_d   = m_q;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (sub_ge) begin
          rem_d = sub_diff[pgfs_pkg::COUNT_BITS-1:0];
        end else begin
          rem_d = rem_shift[pgfs_pkg::COUNT_BITS-1:0];
        end
        quo_d = {quo_q[pgfs_pkg::COUNT_BITS-2:0], sub_ge};
        cnt_d = cnt_q + pgfs_pkg::div_cnt_t'(1);
        if (cnt_q == pgfs_pkg::DIV_LAST) begin
          if (rem_d == '0) begin
            f_d     = d_q;
            m_d     = quo_d;
            state_d = StMul;
          end else begin
            // (d + 1)^2 = d^2 + 2d + 1
            dsq_d   = dsq_q + {1'b0, d_q, 1'b1};
            d_d     = d_q + pgfs_pkg::count_t'(1);
            state_d = StCheck;
          end
        end
      end
      StMul: begin
        first_d = product[pgfs_pkg::COUNT_BITS-1:0];
        state_d = StCmp;
      end
      StCmp: begin
        if (first_q >= s_q) begin
          state_d = StFinish;
        end else begin
          state_d = StCheck;
        end
      end
      StFinish: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    s_q     <= s_d;
    m_q     <= m_d;
    d_q     <= d_d;
    dsq_q   <= dsq_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    f_q     <= f_d;
    first_q <= first_d;
    bad_q   <= bad_d;
  end

  // The remaining cofactor is the second dimension, since first * m == N for a nonzero count.
  assign busy_o        = (state_q != StIdle);
  assign done_o        = (state_q == StFinish);
  assign grid_first_o  = pgfs_pkg::field_t'(first_q);
  assign grid_second_o = pgfs_pkg::field_t'(m_q);
  assign bad_count_o   = bad_q;

  a_bad_is_unit_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && bad_count_o |-> grid_first_o == 16'd1 && grid_second_o == 16'd1)
    else $error("zero count did not give a 1 by 1 grid");

  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_busy_ends_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o))
    else $error("busy dropped without a result");

endmodule

`default_nettype wire
